// ----- rtl/shake_detector_with_grace_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the shake detector with grace unit
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHAKE_DETECTOR_WITH_GRACE_UNIT_MACROS_SVH
`define SHAKE_DETECTOR_WITH_GRACE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SDG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdg check failed");

// Next-cycle implication.
`define SDG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdg check failed");

`endif

// ----- rtl/sdg_pkg.sv -----
// ---------------------------------------------------------------------------
// sdg_pkg
// Shared types and constants of the shake detector with grace unit.
// ---------------------------------------------------------------------------
package sdg_pkg;

    localparam int NUM_AXES  = 3;
    localparam int AXIS_W    = 16;
    localparam int SQ_W      = 31;   // square of a 16-bit signed value fits 31 bits
    localparam int MAG_W     = 32;   // sum of three squares fits 32 bits
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_LEVEL_SQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL_SQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_MS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST_MS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_MS       = 3'd5;

    localparam logic [MAG_W-1:0] SHAKE_LEVEL_SQ_RST = 32'd156900000;
    localparam logic [MAG_W-1:0] REST_LEVEL_SQ_RST  = 32'd84400000;
    localparam logic [DUR_W-1:0] SHAKE_MS_RST       = 16'd300;
    localparam logic [DUR_W-1:0] COOLDOWN_MS_RST    = 16'd1000;
    localparam logic [DUR_W-1:0] REST_MS_RST        = 16'd500;
    localparam logic [DUR_W-1:0] GRACE_MS_RST       = 16'd150;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic [SQ_W-1:0]          sq_t;

    typedef struct packed {
        logic [MAG_W-1:0] shake_level_sq;
        logic [MAG_W-1:0] rest_level_sq;
        logic [DUR_W-1:0] shake_ms;
        logic [DUR_W-1:0] cooldown_ms;
        logic [DUR_W-1:0] rest_ms;
        logic [DUR_W-1:0] grace_ms;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [MAG_W-1:0]  mag;
        logic [TIME_W-1:0] time_ms;
    } step_t;

    typedef struct packed {
        logic       valid;
        logic       roll_trigger;
        logic [1:0] mode;
        logic       is_ready;
    } result_t;

endpackage

// ----- rtl/sdg_if.sv -----
// ---------------------------------------------------------------------------
// sdg_sample_if / sdg_status_if
// Valid/ready channels for accelerometer samples and detector status.
// ---------------------------------------------------------------------------
interface sdg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface sdg_status_if;
    logic       valid;
    logic       ready;
    logic       roll_trigger;
    logic [1:0] mode;
    logic       is_ready;

    modport source (output valid, roll_trigger, mode, is_ready, input ready);
    modport sink   (input valid, roll_trigger, mode, is_ready, output ready);
endinterface

// ----- rtl/shake_detector_with_grace_unit.sv -----
// ---------------------------------------------------------------------------
// shake_detector_with_grace_unit
// Accelerometer shake detector: per-axis squaring lanes, a magnitude merge
// stage and the mode sequencer with its result register.
// ---------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  sample    in   valid/ready   accel_x, accel_y, accel_z, time_ms
//  status    out  valid/ready   roll_trigger, mode, is_ready
//  cfg       in   cfg_we        cfg_index, cfg_data
//
//  One sample per clock when status is taken; status valid rises after its
//  sample beat passes the square lane, magnitude sum and mode update registers.
//  The mode update loop closes on its own state registers.
//  A stalled status beat backs the pipe up one stage at a time; every stage
//  holds its data until the next one frees.
//  rst_n clears the mode state and stage valids and sets config registers to defaults.
// ---------------------------------------------------------------------------
module shake_detector_with_grace_unit
    import sdg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sdg_sample_if.sink           sample,
    sdg_status_if.source         status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t              cfg_reg;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic [TIME_W-1:0] s2_time_reg;

    axis_t             axes    [NUM_AXES];
    sq_t               squares [NUM_AXES];
    logic [MAG_W-1:0]  mag;
    step_t             step;
    logic              step_ready;
    result_t           result;

    logic              in_fire;
    logic              s2_free;
    logic              s1_adv;

    assign s2_free      = !s2_valid_reg || step_ready;
    assign s1_adv       = s1_valid_reg && s2_free;
    assign sample.ready = !s1_valid_reg || s2_free;
    assign in_fire      = sample.valid && sample.ready;

    assign axes[0] = sample.accel_x;
    assign axes[1] = sample.accel_y;
    assign axes[2] = sample.accel_z;

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        sdg_axis_lane u_lane (
            .clk    (clk),
            .en     (in_fire),
            .sample (axes[g]),
            .square (squares[g])
        );
    end

    sdg_mag_merge u_merge (
        .clk     (clk),
        .en      (s1_adv),
        .squares (squares),
        .mag     (mag)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_time_reg <= sample.time_ms;
        end
        if (s1_adv)
        begin
            s2_time_reg <= s1_time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shake_level_sq <= SHAKE_LEVEL_SQ_RST;
            cfg_reg.rest_level_sq  <= REST_LEVEL_SQ_RST;
            cfg_reg.shake_ms       <= SHAKE_MS_RST;
            cfg_reg.cooldown_ms    <= COOLDOWN_MS_RST;
            cfg_reg.rest_ms        <= REST_MS_RST;
            cfg_reg.grace_ms       <= GRACE_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHAKE_LEVEL_SQ: cfg_reg.shake_level_sq <= cfg_data[MAG_W-1:0];
                REG_REST_LEVEL_SQ:  cfg_reg.rest_level_sq  <= cfg_data[MAG_W-1:0];
                REG_SHAKE_MS:       cfg_reg.shake_ms       <= cfg_data[DUR_W-1:0];
                REG_COOLDOWN_MS:    cfg_reg.cooldown_ms    <= cfg_data[DUR_W-1:0];
                REG_REST_MS:        cfg_reg.rest_ms        <= cfg_data[DUR_W-1:0];
                REG_GRACE_MS:       cfg_reg.grace_ms       <= cfg_data[DUR_W-1:0];
                default:            ;
            endcase
        end
    end

    assign step.valid   = s2_valid_reg;
    assign step.mag     = mag;
    assign step.time_ms = s2_time_reg;

    sdg_mode_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step       (step),
        .step_ready (step_ready),
        .out_take   (status.ready),
        .result     (result)
    );

    assign status.valid        = result.valid;
    assign status.roll_trigger = result.roll_trigger;
    assign status.mode         = result.mode;
    assign status.is_ready     = result.is_ready;

endmodule

// ----- rtl/sdg_axis_lane.sv -----
// ---------------------------------------------------------------------------
// sdg_axis_lane
// Squares one signed axis sample and registers the result.
// ---------------------------------------------------------------------------
module sdg_axis_lane
    import sdg_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  axis_t sample,
    output sq_t   square
);

    logic signed [2*AXIS_W-1:0] prod;
    sq_t                        square_reg;

    assign prod = (2*AXIS_W)'(sample) * (2*AXIS_W)'(sample);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            square_reg <= prod[SQ_W-1:0];
        end
    end

    assign square = square_reg;

endmodule

// ----- rtl/sdg_mag_merge.sv -----
// ---------------------------------------------------------------------------
// sdg_mag_merge
// Sums the per-axis squares into the registered squared magnitude.
// ---------------------------------------------------------------------------
module sdg_mag_merge
    import sdg_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  sq_t              squares [NUM_AXES],
    output logic [MAG_W-1:0] mag
);

    logic [MAG_W-1:0] sum;
    logic [MAG_W-1:0] mag_reg;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sum = sum + MAG_W'(squares[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= sum;
        end
    end

    assign mag = mag_reg;

endmodule

// ----- rtl/sdg_mode_fsm.sv -----
// ---------------------------------------------------------------------------
// sdg_mode_fsm
// Mode sequencer: rest wait, ready, shaking with grace, cooldown; holds the
// result register toward the output channel.
// ---------------------------------------------------------------------------
`include "shake_detector_with_grace_unit_macros.svh"

module sdg_mode_fsm
    import sdg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  step_t   step,
    output logic    step_ready,
    input  logic    out_take,
    output result_t result
);

    typedef enum logic [1:0] {
        MODE_WAIT_REST = 2'd0,
        MODE_READY     = 2'd1,
        MODE_SHAKING   = 2'd2,
        MODE_COOLDOWN  = 2'd3
    } mode_t;

    mode_t             state_reg, state_next;
    logic [TIME_W-1:0] shake_begin_reg, shake_begin_next;
    logic [TIME_W-1:0] grace_deadline_reg, grace_deadline_next;
    logic              grace_armed_reg, grace_armed_next;
    logic [TIME_W-1:0] cooldown_deadline_reg, cooldown_deadline_next;
    logic [TIME_W-1:0] rest_begin_reg, rest_begin_next;
    logic              rest_armed_reg, rest_armed_next;
    logic              out_valid_reg;
    logic              trig_reg, trig_next;

    logic              step_fire;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] shake_elapsed;
    logic [TIME_W-1:0] rest_elapsed;
    logic [TIME_W-1:0] grace_diff;
    logic [TIME_W-1:0] cool_diff;
    logic              grace_reached;
    logic              cool_reached;
    logic              above_shake;
    logic              below_rest;

    assign step_ready = !out_valid_reg || out_take;
    assign step_fire  = step.valid && step_ready;
    assign now        = step.time_ms;

    assign shake_elapsed = now - shake_begin_reg;
    assign rest_elapsed  = now - rest_begin_reg;
    assign grace_diff    = now - grace_deadline_reg;
    assign cool_diff     = now - cooldown_deadline_reg;
    // a deadline counts as reached while the wrapped difference is non-negative
    assign grace_reached = !grace_diff[TIME_W-1];
    assign cool_reached  = !cool_diff[TIME_W-1];
    assign above_shake   = step.mag > cfg.shake_level_sq;
    assign below_rest    = step.mag < cfg.rest_level_sq;

    always_comb
    begin
        logic abandon;
        abandon                = 1'b0;
        state_next             = state_reg;
        shake_begin_next       = shake_begin_reg;
        grace_deadline_next    = grace_deadline_reg;
        grace_armed_next       = grace_armed_reg;
        cooldown_deadline_next = cooldown_deadline_reg;
        rest_begin_next        = rest_begin_reg;
        rest_armed_next        = rest_armed_reg;
        trig_next              = 1'b0;

        unique case (state_reg)
            MODE_READY:
            begin
                if (above_shake)
                begin
                    shake_begin_next = now;
                    grace_armed_next = 1'b0;
                    state_next       = MODE_SHAKING;
                end
            end
            MODE_SHAKING:
            begin
                if (step.mag >= cfg.shake_level_sq)
                begin
                    grace_armed_next = 1'b0;
                end
                else if (!grace_armed_reg)
                begin
                    grace_deadline_next = now + TIME_W'(cfg.grace_ms);
                    grace_armed_next    = 1'b1;
                end
                else if (grace_reached)
                begin
                    // dip outlasted the grace window: drop the shake
                    abandon    = 1'b1;
                    state_next = MODE_READY;
                end
                if (!abandon && (shake_elapsed >= TIME_W'(cfg.shake_ms)))
                begin
                    trig_next              = 1'b1;
                    cooldown_deadline_next = now + TIME_W'(cfg.cooldown_ms);
                    state_next             = MODE_COOLDOWN;
                end
            end
            MODE_COOLDOWN:
            begin
                if (cool_reached)
                begin
                    rest_armed_next = 1'b0;
                    state_next      = MODE_WAIT_REST;
                end
            end
            MODE_WAIT_REST:
            begin
                if (below_rest)
                begin
                    if (!rest_armed_reg)
                    begin
                        rest_begin_next = now;
                        rest_armed_next = 1'b1;
                    end
                    else if (rest_elapsed >= TIME_W'(cfg.rest_ms))
                    begin
                        state_next = MODE_READY;
                    end
                end
                else
                begin
                    rest_armed_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= MODE_WAIT_REST;
            shake_begin_reg       <= '0;
            grace_deadline_reg    <= '0;
            grace_armed_reg       <= 1'b0;
            cooldown_deadline_reg <= '0;
            rest_begin_reg        <= '0;
            rest_armed_reg        <= 1'b0;
            out_valid_reg         <= 1'b0;
            trig_reg              <= 1'b0;
        end
        else
        begin
            if (step_fire)
            begin
                state_reg             <= state_next;
                shake_begin_reg       <= shake_begin_next;
                grace_deadline_reg    <= grace_deadline_next;
                grace_armed_reg       <= grace_armed_next;
                cooldown_deadline_reg <= cooldown_deadline_next;
                rest_begin_reg        <= rest_begin_next;
                rest_armed_reg        <= rest_armed_next;
                trig_reg              <= trig_next;
                out_valid_reg         <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.roll_trigger = trig_reg;
    assign result.mode         = state_reg;
    assign result.is_ready     = (state_reg == MODE_READY);

    `SDG_ASSERT_NOW(a_trig_in_cooldown, out_valid_reg && trig_reg, state_reg == MODE_COOLDOWN)
    `SDG_ASSERT_NEXT(a_hold_without_step, !step_fire, $stable(state_reg) && $stable(trig_reg))
    `SDG_ASSERT_NEXT(a_no_trig_from_cooldown, step_fire && state_reg == MODE_COOLDOWN, !trig_reg)
    `SDG_ASSERT_NEXT(a_rest_disarmed_on_exit,
        step_fire && state_reg == MODE_COOLDOWN && cool_reached, !rest_armed_reg)

endmodule
